FILE: hdl/assert_macros.svh
// assertion macros shared by the sphere texcoord design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define STG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stg assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define STG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stg assertion failed");

`endif

FILE: hdl/stg_pkg.sv
// shared types, widths, angle table and output mapping for the texcoord block
package stg_pkg;

  localparam int COORD_W      = 32;
  localparam int DIFF_W       = 33;
  localparam int M_W          = 30;
  localparam int SQ_W         = 60;
  localparam int SUM_W        = 61;
  localparam int ROOT_W       = 31;
  localparam int A_W          = 31;
  localparam int CORDIC_STEPS = 30;
  localparam int XY_W         = 35;
  localparam int Z_W          = 33;
  localparam int OUT_W        = 16;
  localparam int CFG_IDX_W    = 2;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;

  localparam logic signed [Z_W-1:0]   ANGLE_ONE  = 33'sh0_4000_0000;
  localparam logic signed [Z_W-1:0]   ROUND_HALF = 33'sh0_0000_8000;
  localparam logic signed [OUT_W-1:0] HALF_Q214  = 16'sd8192;

  // floor sqrt state handed from cell to cell
  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } stg_root_t;

  // cordic vector handed from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } stg_vec_t;

  // atan(2^-i) with pi/2 = 2^30
  function automatic logic [31:0] ang(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // clamp angle, round half up to q2.14 and add 0.5
  function automatic logic signed [OUT_W-1:0] to_coord(input logic signed [Z_W-1:0] z);
    logic signed [Z_W-1:0] zc;
    logic signed [Z_W-1:0] q;
    zc = z;
    if (z > ANGLE_ONE) begin
      zc = ANGLE_ONE;
    end else if (z < -ANGLE_ONE) begin
      zc = -ANGLE_ONE;
    end
    q = (zc + ROUND_HALF) >>> 16;
    q = q + Z_W'(HALF_Q214);
    return q[OUT_W-1:0];
  endfunction

endpackage

FILE: hdl/stg_sqrt_cell.sv
// one result bit of the floor square root, registered
module stg_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  stg_pkg::stg_root_t in_st,
  output stg_pkg::stg_root_t out_st_r
);

  localparam int CW = stg_pkg::SUM_W + 2;

  logic [CW-1:0]           cand;
  stg_pkg::stg_root_t      out_st_nxt;

  // try setting this bit: remainder must cover 2*root*2^bit + 4^bit
  always_comb begin
    cand = (CW'(in_st.root) << (BIT + 1)) + (CW'(1) << (2 * BIT));
    out_st_nxt = in_st;
    if (CW'(in_st.rem) >= cand) begin
      out_st_nxt.rem  = in_st.rem - cand[stg_pkg::SUM_W-1:0];
      out_st_nxt.root = in_st.root | (stg_pkg::ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    out_st_r <= out_st_nxt;
  end

endmodule

FILE: hdl/stg_cordic_cell.sv
// one vectoring cordic iteration, registered
module stg_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  stg_pkg::stg_vec_t in_v,
  output stg_pkg::stg_vec_t out_v_r
);

  logic signed [stg_pkg::XY_W-1:0] xs;
  logic signed [stg_pkg::XY_W-1:0] ys;
  logic signed [stg_pkg::Z_W-1:0]  a;
  stg_pkg::stg_vec_t               out_v_nxt;

  // rotate toward the x axis and accumulate the angle
  always_comb begin
    xs = in_v.x >>> STEP;
    ys = in_v.y >>> STEP;
    a  = $signed({1'b0, stg_pkg::ang(5'(STEP))});
    if (!in_v.y[stg_pkg::XY_W-1]) begin
      out_v_nxt.x = in_v.x + ys;
      out_v_nxt.y = in_v.y - xs;
      out_v_nxt.z = in_v.z + a;
    end else begin
      out_v_nxt.x = in_v.x - ys;
      out_v_nxt.y = in_v.y + xs;
      out_v_nxt.z = in_v.z - a;
    end
  end

  always_ff @(posedge clk) begin
    out_v_r <= out_v_nxt;
  end

endmodule

FILE: hdl/sphere_texcoord_generator.sv
// top level: sphere texture coordinate pipeline
//
// Usage: write the sphere center with cfg_we/cfg_index/cfg_data (index 0..2 for
// center x, y, z, signed q16.16); other indexes are ignored. Write only while
// no vertex is in flight.
// A vertex beat (in_point_x/y/z, signed q16.16) is taken on every edge where
// start is high; busy is always low, so one vertex enters per cycle.
// Each vertex gives one result beat: out_valid is high for one
// cycle with out_s_coord, out_t_coord (signed q2.14) and out_degenerate.
// The pipeline: front stages for difference, magnitude, max, normalize, square and sum,
// 31 floor-sqrt cells (one root bit each), 30 cordic cells, one output stage.
// Throughput is one vertex per cycle at any load.
// Reset clears the center registers to zero and empties the pipeline; no
// result beats follow reset until new vertices come in.
// The receiver cannot stall: each result beat is shown for one cycle only.
// A vertex equal to the center gives s = t = 0.5 and out_degenerate high.
`include "assert_macros.svh"

module sphere_texcoord_generator (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [stg_pkg::COORD_W-1:0]      in_point_x,
  input  logic signed [stg_pkg::COORD_W-1:0]      in_point_y,
  input  logic signed [stg_pkg::COORD_W-1:0]      in_point_z,
  output logic                                    out_valid,
  output logic signed [stg_pkg::OUT_W-1:0]        out_s_coord,
  output logic signed [stg_pkg::OUT_W-1:0]        out_t_coord,
  output logic                                    out_degenerate,
  input  logic                                    cfg_we,
  input  logic [stg_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [stg_pkg::COORD_W-1:0]             cfg_data
);

  localparam int NSQ  = stg_pkg::ROOT_W;
  localparam int NCO  = stg_pkg::CORDIC_STEPS;
  localparam int LAT  = 7 + NSQ + NCO + 1;
  localparam int DLEN = NSQ + NCO;

  logic signed [stg_pkg::COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [LAT-1:0]                     valid_r;
  logic                               accept;

  logic signed [stg_pkg::DIFF_W-1:0]  d_r    [3];
  logic [stg_pkg::DIFF_W-1:0]         mag1_r [3];
  logic [2:0]                         neg1_r;
  logic [stg_pkg::DIFF_W-1:0]         mag2_r [3];
  logic [2:0]                         neg2_r;
  logic [stg_pkg::DIFF_W-1:0]         big_r;
  logic [stg_pkg::DIFF_W-1:0]         mag3_r [3];
  logic [2:0]                         neg3_r;
  logic [5:0]                         msb_r;
  logic [5:0]                         msb_nxt;
  logic                               deg3_r;
  logic [stg_pkg::M_W-1:0]            m_r    [3];
  logic [stg_pkg::M_W-1:0]            m_nxt  [3];
  logic [2:0]                         neg4_r;
  logic                               deg4_r;
  logic [stg_pkg::SQ_W-1:0]           sq_r   [3];
  logic signed [stg_pkg::A_W-1:0]     as5_r, at5_r;
  logic                               deg5_r;
  logic [stg_pkg::SUM_W-1:0]          ns_r, nt_r;
  logic signed [stg_pkg::A_W-1:0]     as6_r, at6_r;
  logic                               deg6_r;
  logic signed [stg_pkg::A_W-1:0]     as_line_r [NSQ];
  logic signed [stg_pkg::A_W-1:0]     at_line_r [NSQ];
  logic                               deg_line_r [DLEN];

  stg_pkg::stg_root_t                 root_s [NSQ+1];
  stg_pkg::stg_root_t                 root_t [NSQ+1];
  stg_pkg::stg_vec_t                  vec_s  [NCO+1];
  stg_pkg::stg_vec_t                  vec_t  [NCO+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // center registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stg_pkg::CFG_CENTER_X: center_x_r <= $signed(cfg_data);
        stg_pkg::CFG_CENTER_Y: center_y_r <= $signed(cfg_data);
        stg_pkg::CFG_CENTER_Z: center_z_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // valid line through every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[LAT-2:0], accept};
    end
  end

  // largest magnitude's top bit position
  always_comb begin
    msb_nxt = '0;
    for (int i = 0; i < stg_pkg::DIFF_W; i++) begin
      if (big_r[i]) msb_nxt = 6'(i);
    end
  end

  // shift so the largest magnitude lands in [2^29, 2^30)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb_r >= 6'd30) begin
        m_nxt[i] = stg_pkg::M_W'(mag3_r[i] >> (msb_r - 6'd29));
      end else begin
        m_nxt[i] = stg_pkg::M_W'(mag3_r[i] << (6'd29 - msb_r));
      end
    end
  end

  // front stages: difference, magnitude, max, normalize, square, sum
  always_ff @(posedge clk) begin
    d_r[0] <= $signed({in_point_x[31], in_point_x}) - $signed({center_x_r[31], center_x_r});
    d_r[1] <= $signed({in_point_y[31], in_point_y}) - $signed({center_y_r[31], center_y_r});
    d_r[2] <= $signed({in_point_z[31], in_point_z}) - $signed({center_z_r[31], center_z_r});
    for (int i = 0; i < 3; i++) begin
      neg1_r[i] <= d_r[i][stg_pkg::DIFF_W-1];
      mag1_r[i] <= d_r[i][stg_pkg::DIFF_W-1] ? 33'(-d_r[i]) : 33'(d_r[i]);
    end
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
    if (mag1_r[0] >= mag1_r[1] && mag1_r[0] >= mag1_r[2]) begin
      big_r <= mag1_r[0];
    end else if (mag1_r[1] >= mag1_r[2]) begin
      big_r <= mag1_r[1];
    end else begin
      big_r <= mag1_r[2];
    end
    mag3_r <= mag2_r;
    neg3_r <= neg2_r;
    msb_r  <= msb_nxt;
    deg3_r <= (big_r == '0);
    m_r    <= m_nxt;
    neg4_r <= neg3_r;
    deg4_r <= deg3_r;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= m_r[i] * m_r[i];
    end
    as5_r  <= neg4_r[0] ? -$signed({1'b0, m_r[0]}) : $signed({1'b0, m_r[0]});
    at5_r  <= neg4_r[1] ? -$signed({1'b0, m_r[1]}) : $signed({1'b0, m_r[1]});
    deg5_r <= deg4_r;
    ns_r   <= stg_pkg::SUM_W'(sq_r[1]) + stg_pkg::SUM_W'(sq_r[2]);
    nt_r   <= stg_pkg::SUM_W'(sq_r[0]) + stg_pkg::SUM_W'(sq_r[2]);
    as6_r  <= as5_r;
    at6_r  <= at5_r;
    deg6_r <= deg5_r;
  end

  // side lines that ride along the cell chains
  always_ff @(posedge clk) begin
    as_line_r[0]  <= as6_r;
    at_line_r[0]  <= at6_r;
    deg_line_r[0] <= deg6_r;
    for (int i = 1; i < NSQ; i++) begin
      as_line_r[i] <= as_line_r[i-1];
      at_line_r[i] <= at_line_r[i-1];
    end
    for (int i = 1; i < DLEN; i++) begin
      deg_line_r[i] <= deg_line_r[i-1];
    end
  end

  // floor sqrt chains, one root bit per cell, top bit first
  assign root_s[0] = '{rem: ns_r, root: '0};
  assign root_t[0] = '{rem: nt_r, root: '0};

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    stg_sqrt_cell #(.BIT(NSQ - 1 - k)) u_sqrt_s (
      .clk      (clk),
      .in_st    (root_s[k]),
      .out_st_r (root_s[k+1])
    );
    stg_sqrt_cell #(.BIT(NSQ - 1 - k)) u_sqrt_t (
      .clk      (clk),
      .in_st    (root_t[k]),
      .out_st_r (root_t[k+1])
    );
  end

  // cordic chains start from (root, signed component, 0)
  assign vec_s[0] = '{x: $signed(stg_pkg::XY_W'(root_s[NSQ].root)),
                      y: stg_pkg::XY_W'(as_line_r[NSQ-1]),
                      z: '0};
  assign vec_t[0] = '{x: $signed(stg_pkg::XY_W'(root_t[NSQ].root)),
                      y: stg_pkg::XY_W'(at_line_r[NSQ-1]),
                      z: '0};

  for (genvar k = 0; k < NCO; k++) begin : g_cordic
    stg_cordic_cell #(.STEP(k)) u_cordic_s (
      .clk     (clk),
      .in_v    (vec_s[k]),
      .out_v_r (vec_s[k+1])
    );
    stg_cordic_cell #(.STEP(k)) u_cordic_t (
      .clk     (clk),
      .in_v    (vec_t[k]),
      .out_v_r (vec_t[k+1])
    );
  end

  // output beat
  always_ff @(posedge clk) begin
    if (deg_line_r[DLEN-1]) begin
      out_s_coord <= stg_pkg::HALF_Q214;
      out_t_coord <= stg_pkg::HALF_Q214;
    end else begin
      out_s_coord <= stg_pkg::to_coord(vec_s[NCO].z);
      out_t_coord <= stg_pkg::to_coord(vec_t[NCO].z);
    end
    out_degenerate <= deg_line_r[DLEN-1];
  end

  assign out_valid = valid_r[LAT-1];

  // every result beat comes from an accepted vertex
  `STG_ASSERT_IMP(a_out_from_accept, out_valid, $past(accept, LAT))
  // a zero-length ray reports the sphere middle on both axes
  `STG_ASSERT_IMP(a_deg_half, out_valid && out_degenerate,
                  out_s_coord == stg_pkg::HALF_Q214 && out_t_coord == stg_pkg::HALF_Q214)
  // the s coordinate stays within -0.5 .. 1.5
  `STG_ASSERT_IMP(a_s_range, out_valid, out_s_coord >= -16'sd8192 && out_s_coord <= 16'sd24576)
  // no accepted vertex may be dropped on its way out
  `STG_ASSERT_NXT(a_valid_shift, valid_r[LAT-2], out_valid)

endmodule
